// ----- src/hcf_pkg.sv -----
// ----------------------------------------------------------------------------
// hcf_pkg: shared constants and tables of the heading filter
// Field widths, angle constants in Q9.16 degrees, register indexes and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package hcf_pkg;

  // Field widths
  localparam int MAG_W     = 16;
  localparam int CAL_W     = 17;
  localparam int RATE_W    = 16;
  localparam int DT_W      = 12;
  localparam int ANG_W     = 25;
  localparam int DAC_W     = 10;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAG_OFFSET_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAG_OFFSET_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_RATE_OFFSET = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_WEIGHT      = 2'd3;

  // Register values after reset
  localparam logic signed [CFG_W-1:0] MAG_OFFSET_X_RST     = -16'sd240;
  localparam logic signed [CFG_W-1:0] MAG_OFFSET_Y_RST     = -16'sd800;
  localparam logic signed [CFG_W-1:0] GYRO_RATE_OFFSET_RST = 16'sd0;
  localparam logic        [CFG_W-1:0] GYRO_WEIGHT_RST      = 16'd62915;

  // Angles in Q9.16 degrees; a full turn is 45 * 2^19
  localparam logic [ANG_W-1:0] FULL_TURN  = 25'd23592960;
  localparam logic [ANG_W-1:0] HALF_TURN  = 25'd11796480;
  localparam int               TURN_SHIFT = 19;
  localparam logic [6:0]       TURN_DIV   = 7'd45;

  // 57.2958 * 16 / 1000 in Q0.16: rad/s Q3.12 times ms into Q9.16 degrees
  localparam logic [15:0] GYRO_GAIN = 16'd60079;

  // Multiple of 45 that lifts the turn count of the predicted angle above zero
  localparam logic [10:0] TURN_BIAS = 11'd720;

  // Serial multiplier shapes: gyro chain and blend
  localparam int GMUL_A_W = 29;
  localparam int GMUL_B_W = 16;
  localparam int CMUL_A_W = 26;
  localparam int CMUL_B_W = 18;

  // CORDIC
  localparam int CORDIC_ITERATIONS_DEFAULT = 16;
  localparam int CORDIC_XY_W  = 20;
  localparam int CORDIC_Z_W   = 26;
  localparam int ATAN_W       = 22;
  localparam int ATAN_IDX_W   = 5;

  // atan(2^-i) in Q.16 degrees, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117305;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/hcf_if.sv -----
// ----------------------------------------------------------------------------
// hcf_if: sample and result channels of the heading filter
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface hcf_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [hcf_pkg::MAG_W-1:0]    mag_x;
  logic signed [hcf_pkg::MAG_W-1:0]    mag_y;
  logic signed [hcf_pkg::RATE_W-1:0]   gyro_rate_z;
  logic        [hcf_pkg::DT_W-1:0]     dt_ms;

  modport source (output valid, mag_x, mag_y, gyro_rate_z, dt_ms, input ready);
  modport sink   (input valid, mag_x, mag_y, gyro_rate_z, dt_ms, output ready);
endinterface

interface hcf_result_if;
  logic                          valid;
  logic                          ready;
  logic [hcf_pkg::ANG_W-1:0]     heading;
  logic [hcf_pkg::DAC_W-1:0]     dac_code;

  modport source (output valid, heading, dac_code, input ready);
  modport sink   (input valid, heading, dac_code, output ready);
endinterface

// ----- src/heading_complementary_filter_unit.sv -----
// ----------------------------------------------------------------------------
// heading_complementary_filter_unit: gyro / magnetometer heading fusion
// Fuses a CORDIC compass heading with the integrated gyro rate and emits the
// heading in Q9.16 degrees together with a 10-bit DAC code.
// ----------------------------------------------------------------------------
// Each accepted sample word yields exactly one result word. The block works
// on one sample at a time: a new sample is accepted only once the result of
// the last one has moved into the output register (the very first sample
// after reset skips the blend and is faster). The time is set by the serial
// datapath: the gyro increment goes through two radix-4 multiplies (rate
// times dt, then the degree gain), a 5-step reduction of the predicted angle
// modulo 360, a blend multiply by one minus alpha and a 10-step division by
// 45 for the DAC code. The CORDIC heading runs beside the gyro chain
// and adds wait time only above 22 iterations. A finished result sits in an
// output register, so the next sample is taken while it waits. Write the
// configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
module heading_complementary_filter_unit #(
  parameter int CORDIC_ITERATIONS = hcf_pkg::CORDIC_ITERATIONS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  hcf_sample_if.sink                        sample,
  hcf_result_if.source                      result,
  input  logic                              cfg_we,
  input  logic [hcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hcf_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int AW = hcf_pkg::ANG_W;
  localparam int GA = hcf_pkg::GMUL_A_W;
  localparam int GB = hcf_pkg::GMUL_B_W;
  localparam int CA = hcf_pkg::CMUL_A_W;
  localparam int CB = hcf_pkg::CMUL_B_W;
  localparam int TS = hcf_pkg::TURN_SHIFT;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;  // wait for a sample
  localparam logic [3:0] S_G1    = 4'd1;  // rate * dt
  localparam logic [3:0] S_G2    = 4'd2;  // * gyro gain
  localparam logic [3:0] S_MOD   = 4'd3;  // predicted angle modulo 360
  localparam logic [3:0] S_WMAG  = 4'd4;  // wait for the compass heading
  localparam logic [3:0] S_CORR  = 4'd5;  // blend multiply
  localparam logic [3:0] S_DLOAD = 4'd6;  // set up DAC division
  localparam logic [3:0] S_DIV   = 4'd7;  // divide by 45
  localparam logic [3:0] S_FIN   = 4'd8;  // hand result to the output register

  localparam logic [3:0] MOD_STEPS = 4'd5;
  localparam logic [3:0] DAC_STEPS = 4'd10;

  logic [3:0] state;

  // Configuration registers
  logic signed [hcf_pkg::CFG_W-1:0] mag_offset_x;
  logic signed [hcf_pkg::CFG_W-1:0] mag_offset_y;
  logic signed [hcf_pkg::CFG_W-1:0] gyro_rate_offset;
  logic        [hcf_pkg::CFG_W-1:0] gyro_weight;

  // Filter state
  logic [AW-1:0] fused;
  logic          started;

  // Working registers
  logic          mag_valid;
  logic [AW-1:0] pred_angle;   // gyro-predicted angle, 0..360
  logic [AW-1:0] angle;        // new fused angle
  logic [TS-1:0] low_bits;     // fraction of a 1/45 turn, kept across the reduction
  logic [5:0]    rem;
  logic [9:0]    dbits;
  logic [9:0]    quo;
  logic [3:0]    dcount;

  // Output register
  logic          res_valid;
  logic [AW-1:0] res_heading;
  logic [hcf_pkg::DAC_W-1:0] res_dac;

  logic accept;
  logic fin_load;

  assign accept       = sample.valid && sample.ready;
  assign sample.ready = (state == S_IDLE);
  assign fin_load     = (state == S_FIN) && (!res_valid || result.ready);

  assign result.valid    = res_valid;
  assign result.heading  = res_heading;
  assign result.dac_code = res_dac;

  // --------------------------------------------------------------------------
  // Calibration: subtract offsets, 17-bit results
  // --------------------------------------------------------------------------
  logic signed [hcf_pkg::CAL_W-1:0] cal_x;
  logic signed [hcf_pkg::CAL_W-1:0] cal_y;
  logic signed [hcf_pkg::CAL_W-1:0] rate;

  assign cal_x = {sample.mag_x[15], sample.mag_x} - {mag_offset_x[15], mag_offset_x};
  assign cal_y = {sample.mag_y[15], sample.mag_y} - {mag_offset_y[15], mag_offset_y};
  assign rate  = {sample.gyro_rate_z[15], sample.gyro_rate_z}
               - {gyro_rate_offset[15], gyro_rate_offset};

  // --------------------------------------------------------------------------
  // Compass heading
  // --------------------------------------------------------------------------
  logic          cordic_done;
  logic [AW-1:0] compass_deg;

  hcf_cordic #(
    .ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .x_in  (cal_x),
    .y_in  (cal_y),
    .done  (cordic_done),
    .angle (compass_deg)
  );

  // --------------------------------------------------------------------------
  // Gyro chain multiplier: first rate * dt, then times the degree gain
  // --------------------------------------------------------------------------
  logic                 gmul_start;
  logic signed [GA-1:0] gmul_a;
  logic        [GB-1:0] gmul_b;
  logic                 gmul_done;
  logic [GA+GB-1:0]     gprod;

  assign gmul_start = accept || ((state == S_G1) && gmul_done);
  assign gmul_a     = (state == S_IDLE) ? GA'(rate) : $signed(gprod[GA-1:0]);
  assign gmul_b     = (state == S_IDLE) ? GB'(sample.dt_ms) : hcf_pkg::GYRO_GAIN;

  hcf_mul #(
    .A_W (GA),
    .B_W (GB)
  ) u_gmul (
    .clk     (clk),
    .rst     (rst),
    .start   (gmul_start),
    .a       (gmul_a),
    .b       (gmul_b),
    .done    (gmul_done),
    .product (gprod)
  );

  // Round the increment half up, add to the stored angle, split off the
  // turn count (units of 1/45 turn) for the modulo reduction.
  logic [GA+GB-1:0] g_round;
  logic [GA-1:0]    delta;
  logic [GA:0]      pred;
  logic [10:0]      turns;

  assign g_round = gprod + (GA+GB)'(32768);
  assign delta   = g_round[GA+GB-1:16];
  assign pred    = {delta[GA-1], delta} + (GA+1)'(fused);
  assign turns   = pred[GA:TS] + hcf_pkg::TURN_BIAS;

  // --------------------------------------------------------------------------
  // Shared restoring divider by 45, one quotient bit per cycle
  // --------------------------------------------------------------------------
  logic [6:0] trial;
  logic       fits;
  logic [5:0] rem_step;

  assign trial    = {rem, dbits[9]};
  assign fits     = (trial >= hcf_pkg::TURN_DIV);
  assign rem_step = fits ? 6'(trial - hcf_pkg::TURN_DIV) : trial[5:0];

  // --------------------------------------------------------------------------
  // Blend: wrap difference into +-180, multiply by one minus alpha
  // --------------------------------------------------------------------------
  logic signed [CA-1:0] diff_raw;
  logic signed [CA-1:0] diff;
  logic signed [CA-1:0] half_s;
  logic signed [CA-1:0] full_s;
  logic        [16:0]   one_minus_alpha;
  logic                 cmul_start;
  logic                 cmul_done;
  logic [CA+CB-1:0]     cprod;

  assign half_s   = $signed(CA'(hcf_pkg::HALF_TURN));
  assign full_s   = $signed(CA'(hcf_pkg::FULL_TURN));
  assign diff_raw = $signed({1'b0, compass_deg}) - $signed({1'b0, pred_angle});

  always_comb begin
    if (diff_raw > half_s) begin
      diff = diff_raw - full_s;
    end else if (diff_raw < -half_s) begin
      diff = diff_raw + full_s;
    end else begin
      diff = diff_raw;
    end
  end

  assign one_minus_alpha = 17'h10000 - {1'b0, gyro_weight};
  assign cmul_start      = (state == S_WMAG) && mag_valid && started;

  hcf_mul #(
    .A_W (CA),
    .B_W (CB)
  ) u_cmul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmul_start),
    .a       (diff),
    .b       (CB'(one_minus_alpha)),
    .done    (cmul_done),
    .product (cprod)
  );

  logic [CA+CB-1:0]     c_round;
  logic signed [AW+1:0] blend;
  logic signed [AW+1:0] full_b;
  logic [AW-1:0]        blend_wrap;

  assign c_round = cprod + (CA+CB)'(32768);
  assign full_b  = $signed((AW+2)'(hcf_pkg::FULL_TURN));
  assign blend   = $signed({2'b00, pred_angle}) + (AW+2)'($signed(c_round[CA+15:16]));

  always_comb begin
    if (blend >= full_b) begin
      blend_wrap = AW'(blend - full_b);
    end else if (blend < 0) begin
      blend_wrap = AW'(blend + full_b);
    end else begin
      blend_wrap = AW'(blend);
    end
  end

  // DAC: floor(angle * 1023 / 2^19) / 45
  logic [AW+9:0] dac_prod;
  logic [15:0]   dac_num;

  assign dac_prod = {angle, 10'b0} - (AW+10)'(angle);
  assign dac_num  = dac_prod[AW+9:TS];

  // --------------------------------------------------------------------------
  // Configuration write port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mag_offset_x     <= hcf_pkg::MAG_OFFSET_X_RST;
      mag_offset_y     <= hcf_pkg::MAG_OFFSET_Y_RST;
      gyro_rate_offset <= hcf_pkg::GYRO_RATE_OFFSET_RST;
      gyro_weight      <= hcf_pkg::GYRO_WEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hcf_pkg::REG_MAG_OFFSET_X:     mag_offset_x     <= cfg_wdata;
        hcf_pkg::REG_MAG_OFFSET_Y:     mag_offset_y     <= cfg_wdata;
        hcf_pkg::REG_GYRO_RATE_OFFSET: gyro_rate_offset <= cfg_wdata;
        hcf_pkg::REG_GYRO_WEIGHT:      gyro_weight      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Compass heading ready flag: drop on a new sample, set when CORDIC ends
  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else if (accept) begin
      mag_valid <= 1'b0;
    end else if (cordic_done) begin
      mag_valid <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fused   <= '0;
      started <= 1'b0;
      dcount  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_G1;
          end
        end
        S_G1: begin
          if (gmul_done) begin
            state <= S_G2;
          end
        end
        S_G2: begin
          if (gmul_done) begin
            // seed the reduction with the top turn bits
            rem      <= turns[10:5];
            dbits    <= {turns[4:0], 5'b0};
            dcount   <= MOD_STEPS;
            low_bits <= pred[TS-1:0];
            state    <= S_MOD;
          end
        end
        S_MOD: begin
          rem    <= rem_step;
          dbits  <= {dbits[8:0], 1'b0};
          quo    <= {quo[8:0], fits};
          dcount <= dcount - 1'b1;
          if (dcount == 4'd1) begin
            pred_angle <= {rem_step, low_bits};
            state      <= S_WMAG;
          end
        end
        S_WMAG: begin
          if (mag_valid) begin
            if (started) begin
              state <= S_CORR;
            end else begin
              // first sample: take the compass heading as is
              angle <= compass_deg;
              state <= S_DLOAD;
            end
          end
        end
        S_CORR: begin
          if (cmul_done) begin
            angle <= blend_wrap;
            state <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          rem    <= dac_num[15:10];
          dbits  <= dac_num[9:0];
          dcount <= DAC_STEPS;
          state  <= S_DIV;
        end
        S_DIV: begin
          rem    <= rem_step;
          dbits  <= {dbits[8:0], 1'b0};
          quo    <= {quo[8:0], fits};
          dcount <= dcount - 1'b1;
          if (dcount == 4'd1) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            fused   <= angle;
            started <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: hold until taken, load when empty or being emptied
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fin_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      res_heading <= angle;
      res_dac     <= quo;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.heading < hcf_pkg::FULL_TURN))
    else $error("heading word out of 0..360");

  a_fused_range: assert property (@(posedge clk) disable iff (rst)
    started |-> (fused < hcf_pkg::FULL_TURN))
    else $error("stored angle out of 0..360");

  a_gmul_state: assert property (@(posedge clk) disable iff (rst)
    gmul_done |-> (state == S_G1 || state == S_G2))
    else $error("gyro multiplier finished outside the gyro chain");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD || state == S_DIV) |-> (rem < 6'(hcf_pkg::TURN_DIV)))
    else $error("divider remainder not below 45");

  a_blend_has_mag: assert property (@(posedge clk) disable iff (rst)
    (state == S_CORR) |-> mag_valid)
    else $error("blend running without a compass heading");

endmodule

// ----- src/hcf_mul.sv -----
// ----------------------------------------------------------------------------
// hcf_mul: radix-4 serial multiplier
// Signed A times unsigned B, two bits of B per cycle.
// ----------------------------------------------------------------------------
module hcf_mul #(
  parameter int A_W = hcf_pkg::GMUL_A_W,
  parameter int B_W = hcf_pkg::GMUL_B_W   // even
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [A_W-1:0] a,
  input  logic        [B_W-1:0] b,
  output logic                  done,
  output logic [A_W+B_W-1:0]    product
);

  localparam int STEPS = B_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic signed [A_W:0]   hi;
  logic        [B_W-1:0] lo;
  logic signed [A_W+2:0] a1;
  logic signed [A_W+2:0] a3;
  logic        [CNT_W-1:0] count;

  logic signed [A_W+2:0] addend;
  logic signed [A_W+2:0] sum;

  always_comb begin
    case (lo[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = a1;
      2'd2:    addend = a1 <<< 1;
      2'd3:    addend = a3;
      default: addend = '0;
    endcase
    sum = (A_W+3)'(hi) + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        hi    <= '0;
        lo    <= b;
        a1    <= (A_W+3)'(a);
        a3    <= (A_W+3)'(a) + ((A_W+3)'(a) <<< 1);
        count <= CNT_W'(STEPS);
      end else if (count != '0) begin
        // accumulate one digit, then shift the partial product right by two
        hi    <= sum[A_W+2:2];
        lo    <= {sum[1:0], lo[B_W-1:2]};
        count <= count - 1'b1;
        done  <= (count == CNT_W'(1));
      end
    end
  end

  assign product = {hi[A_W-1:0], lo};

endmodule

// ----- src/hcf_cordic.sv -----
// ----------------------------------------------------------------------------
// hcf_cordic: iterative vectoring CORDIC, atan2 in Q9.16 degrees
// One micro-rotation per cycle; result wrapped into 0..360.
// ----------------------------------------------------------------------------
module hcf_cordic #(
  parameter int ITERATIONS = hcf_pkg::CORDIC_ITERATIONS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [hcf_pkg::CAL_W-1:0]  x_in,
  input  logic signed [hcf_pkg::CAL_W-1:0]  y_in,
  output logic                              done,
  output logic [hcf_pkg::ANG_W-1:0]         angle
);

  localparam int IW  = $clog2(ITERATIONS);
  localparam int XW  = hcf_pkg::CORDIC_XY_W;
  localparam int ZW  = hcf_pkg::CORDIC_Z_W;

  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  logic signed [ZW-1:0] z;
  logic        [IW-1:0] iter;
  logic                 busy;
  logic                 zero;

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic signed [ZW-1:0] z_next;
  logic signed [ZW-1:0] at;
  logic signed [ZW-1:0] z_wrap;
  logic signed [ZW-1:0] full_s;

  assign xs     = XW'(x_in);
  assign ys     = XW'(y_in);
  assign full_s = $signed(ZW'(hcf_pkg::FULL_TURN));

  always_comb begin
    at = $signed(ZW'(hcf_pkg::atan_q16(hcf_pkg::ATAN_IDX_W'(iter))));
    if (!y[XW-1]) begin
      x_next = x + (y >>> iter);
      y_next = y - (x >>> iter);
      z_next = z + at;
    end else begin
      x_next = x - (y >>> iter);
      y_next = y + (x >>> iter);
      z_next = z - at;
    end
    if (z_next < 0) begin
      z_wrap = z_next + full_s;
    end else if (z_next >= full_s) begin
      z_wrap = z_next - full_s;
    end else begin
      z_wrap = z_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
        zero <= (x_in == '0) && (y_in == '0);
        // left half plane: rotate by 180 first
        if (x_in[hcf_pkg::CAL_W-1]) begin
          x <= -xs;
          y <= -ys;
          z <= $signed(ZW'(hcf_pkg::HALF_TURN));
        end else begin
          x <= xs;
          y <= ys;
          z <= '0;
        end
      end else if (busy) begin
        x    <= x_next;
        y    <= y_next;
        z    <= z_next;
        iter <= iter + 1'b1;
        if (iter == IW'(ITERATIONS - 1)) begin
          busy  <= 1'b0;
          done  <= 1'b1;
          angle <= zero ? '0 : z_wrap[hcf_pkg::ANG_W-1:0];
        end
      end
    end
  end

endmodule
